### rtl/core/fbs_pkg.sv
// Shared constants and types for the face box stabilizer.
`default_nettype none

package fbs_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOUTH_RULE     = 1'd1;

    // Register widths and reset values.
    localparam int THR_W = 9;
    localparam int RULE_W = 2;
    localparam logic [THR_W-1:0] THR_RESET = 9'd205;

    // The threshold counts in 1/256 units.
    localparam int THR_FRAC_BITS = 8;

    // Mouth derivation rules; the unused code behaves as the mixed rule.
    typedef enum logic [RULE_W-1:0] {
        RULE_THIRDS   = 2'd0,
        RULE_QUARTERS = 2'd1,
        RULE_MIXED    = 2'd2
    } mouth_rule_t;

    // Constant divisors used by the mouth rules.
    localparam int DIVISOR_W = 4;
    localparam logic [DIVISOR_W-1:0] DIV_THIRD     = 4'd3;
    localparam logic [DIVISOR_W-1:0] DIV_FIFTH     = 4'd5;
    localparam logic [DIVISOR_W-1:0] DIV_FIFTEENTH = 4'd15;

endpackage

`default_nettype wire

### rtl/core/fbs_in_if.sv
// Channel that carries one detected face box per transaction.
`default_nettype none

interface fbs_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] face_left;
    logic [COORD_BITS-1:0] face_top;
    logic [COORD_BITS-1:0] face_span_x;
    logic [COORD_BITS-1:0] face_span_y;

    modport source (
        output valid, face_left, face_top, face_span_x, face_span_y,
        input  ready
    );

    modport sink (
        input  valid, face_left, face_top, face_span_x, face_span_y,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/fbs_out_if.sv
// Channel that carries the stabilized face box and mouth region per transaction.
`default_nettype none

interface fbs_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] kept_left;
    logic [COORD_BITS-1:0] kept_top;
    logic [COORD_BITS-1:0] kept_span_x;
    logic [COORD_BITS-1:0] kept_span_y;
    logic [COORD_BITS:0]   mouth_left;
    logic [COORD_BITS:0]   mouth_top;
    logic [COORD_BITS-1:0] mouth_span_x;
    logic [COORD_BITS-1:0] mouth_span_y;

    modport source (
        output valid, kept_left, kept_top, kept_span_x, kept_span_y,
               mouth_left, mouth_top, mouth_span_x, mouth_span_y,
        input  ready
    );

    modport sink (
        input  valid, kept_left, kept_top, kept_span_x, kept_span_y,
               mouth_left, mouth_top, mouth_span_x, mouth_span_y,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/face_box_stabilizer_mouth_region.sv
// Face box stabilizer: overlap test against the held box, keep decision, mouth region.
// The steps run in order: the overlap test when a box is held, then, when the boxes overlap,
// overlap area, box area and threshold product one after another through the single shared
// multiplier, then the decision and the two constant divisions on the same multiplier.
// A new box is taken once the last result is in the output register; the next box is taken while a result waits.
// Reset clears the held box (nothing held), the registers to threshold 205 and rule 0.
`default_nettype none

module face_box_stabilizer_mouth_region #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    fbs_in_if.sink                          face,
    fbs_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [fbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fbs_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int A_W  = 2 * C;
    localparam int B_W  = C + 1;
    localparam int P_W  = A_W + B_W;
    localparam int K    = C + 1;
    localparam int R_W  = C + DIVISOR_W;

    // Reciprocals scaled by 2^K; one correction step makes the quotient exact.
    localparam logic [B_W-1:0] RECIP3  = B_W'((2 ** K) / 3);
    localparam logic [B_W-1:0] RECIP5  = B_W'((2 ** K) / 5);
    localparam logic [B_W-1:0] RECIP15 = B_W'((2 ** K) / 15);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OVL,
        S_MUL_I,
        S_MUL_A,
        S_MUL_T,
        S_DEC,
        S_DIV1,
        S_DIV2,
        S_FIX2,
        S_DONE
    } state_t;

    state_t           state_reg;

    // Configuration registers.
    logic [THR_W-1:0]  thr_reg;
    logic [RULE_W-1:0] rule_reg;

    // Held box.
    logic [C-1:0] held_left_reg, held_top_reg, held_span_x_reg, held_span_y_reg;

    // Working box: the accepted box, replaced by the held box when it is kept.
    logic [C-1:0] box_left_reg, box_top_reg, box_span_x_reg, box_span_y_reg;

    logic         hit_reg;
    logic [C-1:0] ovx_reg, ovy_reg;
    logic [A_W-1:0] inter_reg;
    logic [C-1:0] q1_reg, q2_reg;

    // Output register.
    logic         out_valid_reg;
    logic [C-1:0] kept_left_reg, kept_top_reg, kept_span_x_reg, kept_span_y_reg;
    logic [C:0]   mouth_left_reg, mouth_top_reg;
    logic [C-1:0] mouth_span_x_reg, mouth_span_y_reg;

    // Shared multiplier.
    logic [A_W-1:0] mul_a;
    logic [B_W-1:0] mul_b;
    logic [P_W-1:0] prod;

    fbs_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Handshake signals.
    logic in_fire, out_load;
    assign face.ready = (state_reg == S_IDLE);
    assign in_fire    = face.valid && face.ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Overlap of the working box with the held box.
    logic [C:0]   new_x1, new_y1, held_x1, held_y1, x1, y1;
    logic [C-1:0] x0, y0;
    logic         hit;
    always_comb
    begin
        new_x1  = {1'b0, box_left_reg} + {1'b0, box_span_x_reg};
        new_y1  = {1'b0, box_top_reg} + {1'b0, box_span_y_reg};
        held_x1 = {1'b0, held_left_reg} + {1'b0, held_span_x_reg};
        held_y1 = {1'b0, held_top_reg} + {1'b0, held_span_y_reg};
        x0 = (box_left_reg > held_left_reg) ? box_left_reg : held_left_reg;
        y0 = (box_top_reg > held_top_reg) ? box_top_reg : held_top_reg;
        x1 = (new_x1 < held_x1) ? new_x1 : held_x1;
        y1 = (new_y1 < held_y1) ? new_y1 : held_y1;
        hit = ({1'b0, x0} < x1) && ({1'b0, y0} < y1);
    end

    // Keep decision: overlap * 256 against threshold * area.
    logic [P_W+THR_FRAC_BITS-1:0] keep_lhs, keep_rhs;
    logic held_busy, keep;
    always_comb
    begin
        keep_lhs  = {{B_W{1'b0}}, inter_reg, {THR_FRAC_BITS{1'b0}}};
        keep_rhs  = {{THR_FRAC_BITS{1'b0}}, prod};
        held_busy = (held_span_y_reg != '0);
        keep      = held_busy && hit_reg && (keep_lhs > keep_rhs);
    end

    // Dividends and divisors of the two constant divisions.
    logic         rule_quarters;
    logic [C:0]   num1, num2, fix_num;
    logic [DIVISOR_W-1:0] div2, fix_div;
    always_comb
    begin
        rule_quarters = (rule_reg == RULE_QUARTERS);
        num1 = rule_quarters ? {box_span_y_reg, 1'b0} : {1'b0, box_span_y_reg};
        num2 = rule_quarters ? {1'b0, box_span_y_reg} : {1'b0, box_span_x_reg};
        div2 = rule_quarters ? DIV_FIFTEENTH : DIV_FIFTH;
        fix_num = (state_reg == S_FIX2) ? num2 : num1;
        fix_div = (state_reg == S_FIX2) ? div2 : DIV_THIRD;
    end

    // Multiplier operand selection by sequencer step.
    always_comb
    begin
        case (state_reg)
            S_MUL_I:
            begin
                mul_a = A_W'(ovx_reg);
                mul_b = B_W'(ovy_reg);
            end
            S_MUL_A:
            begin
                mul_a = A_W'(box_span_x_reg);
                mul_b = B_W'(box_span_y_reg);
            end
            S_MUL_T:
            begin
                mul_a = prod[A_W-1:0];
                mul_b = B_W'(thr_reg);
            end
            S_DIV1:
            begin
                mul_a = A_W'(num1);
                mul_b = RECIP3;
            end
            S_DIV2:
            begin
                mul_a = A_W'(num2);
                mul_b = rule_quarters ? RECIP15 : RECIP5;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Quotient estimate and its one-step correction.
    logic [C-1:0] q_est, q_fix;
    logic [R_W-1:0] q_mul, q_rem;
    always_comb
    begin
        q_est = prod[K +: C];
        q_mul = R_W'(q_est) * R_W'(fix_div);
        q_rem = R_W'(fix_num) - q_mul;
        q_fix = (q_rem >= R_W'(fix_div)) ? (q_est + 1'b1) : q_est;
    end

    // Mouth region from the given box.
    logic [C-1:0] qtr;
    logic [C:0]   mouth_left, mouth_top;
    logic [C-1:0] mouth_span_x, mouth_span_y;
    always_comb
    begin
        qtr = box_span_x_reg >> 2;
        case (rule_reg)
            RULE_THIRDS:
            begin
                mouth_left   = {1'b0, box_left_reg} + {1'b0, q2_reg};
                mouth_top    = {1'b0, box_top_reg} + {q1_reg, 1'b0};
                mouth_span_x = q2_reg + {q2_reg[C-2:0], 1'b0};
                mouth_span_y = q1_reg;
            end
            RULE_QUARTERS:
            begin
                mouth_left   = {1'b0, box_left_reg} + {1'b0, qtr};
                mouth_top    = {1'b0, box_top_reg} + {1'b0, q1_reg};
                mouth_span_x = box_span_x_reg - {qtr[C-2:0], 1'b0};
                mouth_span_y = box_span_y_reg - q2_reg - q1_reg;
            end
            default:
            begin
                mouth_left   = {1'b0, box_left_reg} + {1'b0, qtr};
                mouth_top    = {1'b0, box_top_reg} + {q1_reg, 1'b0};
                mouth_span_x = box_span_x_reg - {qtr[C-2:0], 1'b0};
                mouth_span_y = q1_reg;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            rule_reg <= RULE_THIRDS;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEEP_THRESHOLD)
            begin
                thr_reg <= cfg_data[THR_W-1:0];
            end
            if (cfg_index == REG_MOUTH_RULE)
            begin
                rule_reg <= cfg_data[RULE_W-1:0];
            end
        end
    end

    // Control state and held box.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            held_left_reg   <= '0;
            held_top_reg    <= '0;
            held_span_x_reg <= '0;
            held_span_y_reg <= '0;
        end
        else
        begin
            if (result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= held_busy ? S_OVL : S_DEC;
                    end
                end
                S_OVL:
                begin
                    state_reg <= hit ? S_MUL_I : S_DEC;
                end
                S_MUL_I:
                begin
                    state_reg <= S_MUL_A;
                end
                S_MUL_A:
                begin
                    state_reg <= S_MUL_T;
                end
                S_MUL_T:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (!keep && (!held_busy || hit_reg))
                    begin
                        held_left_reg   <= box_left_reg;
                        held_top_reg    <= box_top_reg;
                        held_span_x_reg <= box_span_x_reg;
                        held_span_y_reg <= box_span_y_reg;
                    end
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    state_reg <= S_FIX2;
                end
                S_FIX2:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            box_left_reg   <= face.face_left;
            box_top_reg    <= face.face_top;
            box_span_x_reg <= face.face_span_x;
            box_span_y_reg <= face.face_span_y;
            hit_reg        <= 1'b0;
        end
        if (state_reg == S_OVL)
        begin
            hit_reg <= hit;
            ovx_reg <= C'(x1 - {1'b0, x0});
            ovy_reg <= C'(y1 - {1'b0, y0});
        end
        if (state_reg == S_MUL_A)
        begin
            inter_reg <= prod[A_W-1:0];
        end
        if ((state_reg == S_DEC) && keep)
        begin
            box_left_reg   <= held_left_reg;
            box_top_reg    <= held_top_reg;
            box_span_x_reg <= held_span_x_reg;
            box_span_y_reg <= held_span_y_reg;
        end
        if (state_reg == S_DIV2)
        begin
            q1_reg <= q_fix;
        end
        if (state_reg == S_FIX2)
        begin
            q2_reg <= q_fix;
        end
        if (out_load)
        begin
            kept_left_reg    <= box_left_reg;
            kept_top_reg     <= box_top_reg;
            kept_span_x_reg  <= box_span_x_reg;
            kept_span_y_reg  <= box_span_y_reg;
            mouth_left_reg   <= mouth_left;
            mouth_top_reg    <= mouth_top;
            mouth_span_x_reg <= mouth_span_x;
            mouth_span_y_reg <= mouth_span_y;
        end
    end

    // Result channel.
    assign result.valid        = out_valid_reg;
    assign result.kept_left    = kept_left_reg;
    assign result.kept_top     = kept_top_reg;
    assign result.kept_span_x  = kept_span_x_reg;
    assign result.kept_span_y  = kept_span_y_reg;
    assign result.mouth_left   = mouth_left_reg;
    assign result.mouth_top    = mouth_top_reg;
    assign result.mouth_span_x = mouth_span_x_reg;
    assign result.mouth_span_y = mouth_span_y_reg;

    // An accepted transaction keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !face.ready)
        else $error("face channel ready right after a transaction was accepted");

    // The held box only changes in the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DEC) |=>
            $stable({held_left_reg, held_top_reg, held_span_x_reg, held_span_y_reg}))
        else $error("held box changed outside the decision step");

    // A finished result reaches the output register and frees the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result.valid && (state_reg == S_IDLE)))
        else $error("finished result was not presented on the result channel");

    // A kept box is always a box that was held.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DEC) && keep) |-> held_busy)
        else $error("kept a box while nothing was held");

endmodule

`default_nettype wire

### rtl/core/fbs_mul.sv
// Shared multiplier with a registered product.
`default_nettype none

module fbs_mul #(
    parameter int A_W = 24,
    parameter int B_W = 13
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);
    // One product per cycle, always registered before use.
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule

`default_nettype wire

### verif/face_box_stabilizer_mouth_region_tb.sv
// Self-checking testbench for the face box stabilizer with mouth region derivation.
`default_nettype none

module face_box_stabilizer_mouth_region_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbs_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_BURST_CYCLES = 300;
    localparam int PHASE_COUNT = 8;
    localparam int BOXES_PER_PHASE = 135;

    // The rule code left unused by the package, which behaves as the mixed rule.
    localparam logic [RULE_W-1:0] RULE_UNUSED = 2'd3;

    // Register settings and idle mix for each random phase.
    localparam int PHASE_THR [PHASE_COUNT] = '{205, 0, 256, 511, 128, 255, 1, 230};
    localparam logic [RULE_W-1:0] PHASE_RULE [PHASE_COUNT] = '{
        RULE_THIRDS, RULE_QUARTERS, RULE_MIXED, RULE_UNUSED,
        RULE_QUARTERS, RULE_THIRDS, RULE_MIXED, RULE_QUARTERS
    };
    localparam int PHASE_SEND_IDLE [PHASE_COUNT] = '{0, 67, 0, 16, 0, 67, 0, 16};
    localparam int PHASE_RECV_STALL [PHASE_COUNT] = '{0, 0, 67, 16, 0, 0, 67, 16};

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] span_x;
        logic [COORD_BITS-1:0] span_y;
    } face_box_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] kept_left;
        logic [COORD_BITS-1:0] kept_top;
        logic [COORD_BITS-1:0] kept_span_x;
        logic [COORD_BITS-1:0] kept_span_y;
        logic [COORD_BITS:0]   mouth_left;
        logic [COORD_BITS:0]   mouth_top;
        logic [COORD_BITS-1:0] mouth_span_x;
        logic [COORD_BITS-1:0] mouth_span_y;
    } stab_result_t;

    typedef enum logic {ROW_BOX, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        face_box_t         box;
        logic [THR_W-1:0]  thr;
        logic [RULE_W-1:0] rule;
        bit                typed;
        stab_result_t      want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fbs_in_if #(.COORD_BITS(COORD_BITS)) face_ch ();
    fbs_out_if #(.COORD_BITS(COORD_BITS)) result_ch ();

    face_box_stabilizer_mouth_region #(.COORD_BITS(COORD_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .face      (face_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: the held box and our copy of the registers.
    face_box_t         held_box;
    logic [THR_W-1:0]  keep_thr;
    logic [RULE_W-1:0] mouth_sel;

    stab_result_t pending_results[$];
    dir_row_t     dir_rows[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           stall_burst_req = 1'b0;

    always #4 clk = ~clk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [COORD_BITS:0] got, logic [COORD_BITS:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Stabilize one accepted box against the held box and derive the mouth region.
    function automatic stab_result_t stabilize_box(face_box_t b);
        stab_result_t r;
        longint unsigned l, t, w, h, x0, y0, x1, y1, overlap, area;
        longint unsigned ml, mt, mw, mh, q, dx, dy, up;
        l = b.left;
        t = b.top;
        w = b.span_x;
        h = b.span_y;
        if (held_box.span_y == '0) begin
            held_box = b;
        end else begin
            x0 = (l > held_box.left) ? l : longint'(held_box.left);
            y0 = (t > held_box.top) ? t : longint'(held_box.top);
            x1 = l + w;
            if (x1 > held_box.left + held_box.span_x)
                x1 = longint'(held_box.left) + longint'(held_box.span_x);
            y1 = t + h;
            if (y1 > held_box.top + held_box.span_y)
                y1 = longint'(held_box.top) + longint'(held_box.span_y);
            if (x0 < x1 && y0 < y1) begin
                overlap = (x1 - x0) * (y1 - y0);
                area = w * h;
                if ((overlap << THR_FRAC_BITS) > longint'(keep_thr) * area) begin
                    l = held_box.left;
                    t = held_box.top;
                    w = held_box.span_x;
                    h = held_box.span_y;
                end else begin
                    held_box = b;
                end
            end
        end

        // Mouth region from the box that is given out.
        if (mouth_sel == RULE_THIRDS) begin
            dy = h / DIV_THIRD;
            dx = w / DIV_FIFTH;
            ml = l + dx;
            mt = t + 2 * dy;
            mw = 3 * dx;
            mh = dy;
        end else if (mouth_sel == RULE_QUARTERS) begin
            q = w / 4;
            up = (2 * h) / DIV_THIRD;
            ml = l + q;
            mt = t + up;
            mw = w - 2 * q;
            mh = h - h / DIV_FIFTEENTH - up;
        end else begin
            q = w / 4;
            dy = h / DIV_THIRD;
            ml = l + q;
            mt = t + 2 * dy;
            mw = w - 2 * q;
            mh = dy;
        end
        r.kept_left    = l[COORD_BITS-1:0];
        r.kept_top     = t[COORD_BITS-1:0];
        r.kept_span_x  = w[COORD_BITS-1:0];
        r.kept_span_y  = h[COORD_BITS-1:0];
        r.mouth_left   = ml[COORD_BITS:0];
        r.mouth_top    = mt[COORD_BITS:0];
        r.mouth_span_x = mw[COORD_BITS-1:0];
        r.mouth_span_y = mh[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] clip_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_MAX[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    function automatic int jitter(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Mostly boxes that track the held box, so keep and store decisions both happen often.
    function automatic face_box_t pick_box();
        face_box_t b;
        logic [63:0] raw;
        int unsigned sel;
        int rx, ry;
        sel = $urandom_range(0, 99);
        rx = int'(held_box.span_x) / 2 + 1;
        ry = int'(held_box.span_y) / 2 + 1;
        if (sel < 45) begin
            b.left   = clip_coord(int'(held_box.left) + jitter(4));
            b.top    = clip_coord(int'(held_box.top) + jitter(4));
            b.span_x = clip_coord(int'(held_box.span_x) + jitter(4));
            b.span_y = clip_coord(int'(held_box.span_y) + jitter(4));
        end else if (sel < 65) begin
            b.left   = clip_coord(int'(held_box.left) + jitter(rx));
            b.top    = clip_coord(int'(held_box.top) + jitter(ry));
            b.span_x = clip_coord(int'(held_box.span_x) + jitter(16));
            b.span_y = clip_coord(int'(held_box.span_y) + jitter(16));
        end else if (sel < 75) begin
            b.left   = COORD_BITS'($urandom);
            b.top    = COORD_BITS'($urandom);
            b.span_x = COORD_BITS'($urandom_range(0, 63));
            b.span_y = COORD_BITS'($urandom_range(0, 63));
        end else begin
            raw = {$urandom, $urandom};
            b = raw[$bits(face_box_t)-1:0];
        end
        if ($urandom_range(0, 19) == 0)
            b.span_x = '0;
        if ($urandom_range(0, 19) == 0)
            b.span_y = '0;
        return b;
    endfunction

    // Offer one box and record its expected result once the transaction completes.
    task automatic offer_box(face_box_t b, bit typed, stab_result_t want);
        stab_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            face_ch.valid <= 1'b0;
            @(posedge clk);
        end
        face_ch.valid       <= 1'b1;
        face_ch.face_left   <= b.left;
        face_ch.face_top    <= b.top;
        face_ch.face_span_x <= b.span_x;
        face_ch.face_span_y <= b.span_y;
        do
            @(posedge clk);
        while (face_ch.ready !== 1'b1);
        predicted = stabilize_box(b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Let the block drain, then write both registers.
    task automatic write_settings(logic [THR_W-1:0] thr, logic [RULE_W-1:0] rule);
        face_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEEP_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= REG_MOUTH_RULE;
        cfg_data  <= CFG_DATA_W'(rule);
        @(posedge clk);
        cfg_we    <= 1'b0;
        keep_thr  = thr;
        mouth_sel = rule;
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int burst_left;
        burst_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (burst_left > 0) begin
                result_ch.ready <= 1'b0;
                burst_left--;
            end else if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                burst_left = STALL_BURST_CYCLES;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    initial begin
        stab_result_t want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    check_field("kept_left", result_ch.kept_left, want.kept_left);
                    check_field("kept_top", result_ch.kept_top, want.kept_top);
                    check_field("kept_span_x", result_ch.kept_span_x, want.kept_span_x);
                    check_field("kept_span_y", result_ch.kept_span_y, want.kept_span_y);
                    check_field("mouth_left", result_ch.mouth_left, want.mouth_left);
                    check_field("mouth_top", result_ch.mouth_top, want.mouth_top);
                    check_field("mouth_span_x", result_ch.mouth_span_x, want.mouth_span_x);
                    check_field("mouth_span_y", result_ch.mouth_span_y, want.mouth_span_y);
                end
            end
        end
    end

    // Stimulus: directed table, then random phases.
    initial begin
        dir_row_t row;
        stab_result_t none;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        face_ch.valid = 1'b0;
        face_ch.face_left = '0;
        face_ch.face_top = '0;
        face_ch.face_span_x = '0;
        face_ch.face_span_y = '0;
        held_box = '0;
        keep_thr = THR_RESET;
        mouth_sel = RULE_THIRDS;

        // Zero height while nothing is held: stored, so still nothing held.
        dir_rows.push_back('{ROW_BOX, '{12'd4095, 12'd4095, 12'd4095, 12'd0}, '0, '0, 1'b1,
            '{12'd4095, 12'd4095, 12'd4095, 12'd0, 13'd4914, 13'd4095, 12'd2457, 12'd0}});
        dir_rows.push_back('{ROW_BOX, '{12'd100, 12'd200, 12'd60, 12'd90}, '0, '0, 1'b1,
            '{12'd100, 12'd200, 12'd60, 12'd90, 13'd112, 13'd260, 12'd36, 12'd30}});
        // Largest box, clear of the held one.
        dir_rows.push_back('{ROW_BOX, '{12'd4095, 12'd4095, 12'd4095, 12'd4095}, '0, '0, 1'b1,
            '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 13'd4914, 13'd6825, 12'd2457, 12'd1365}});
        // Zero-area box passes through.
        dir_rows.push_back('{ROW_BOX, '{12'd0, 12'd0, 12'd0, 12'd0}, '0, '0, 1'b1, none});
        // Nearly the same box: the held one is given again.
        dir_rows.push_back('{ROW_BOX, '{12'd102, 12'd202, 12'd60, 12'd90}, '0, '0, 1'b1,
            '{12'd100, 12'd200, 12'd60, 12'd90, 13'd112, 13'd260, 12'd36, 12'd30}});
        dir_rows.push_back('{ROW_BOX, '{12'd130, 12'd240, 12'd60, 12'd90}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd0, 12'd0, 12'd4095, 12'd4095}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd0, 12'd0, 12'd4095, 12'd4095}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd10, 12'd10, 12'd0, 12'd50}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd4000, 12'd4000, 12'd95, 12'd95}, '0, '0, 1'b0, none});
        // Threshold of exactly one: equal overlap does not keep.
        dir_rows.push_back('{ROW_CFG, '0, 9'd256, RULE_QUARTERS, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd0, 12'd0, 12'd4095, 12'd4095}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd1, 12'd1, 12'd4094, 12'd4094}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd4094, 12'd4094, 12'd1, 12'd1}, '0, '0, 1'b0, none});
        // Threshold above one: never kept.
        dir_rows.push_back('{ROW_CFG, '0, 9'd511, RULE_MIXED, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd4094, 12'd4094, 12'd1, 12'd1}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd4000, 12'd4000, 12'd200, 12'd200}, '0, '0, 1'b0, none});
        // Zero threshold with the unused rule code: any overlap keeps.
        dir_rows.push_back('{ROW_CFG, '0, 9'd0, RULE_UNUSED, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd3000, 12'd3000, 12'd1001, 12'd1001}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd17, 12'd33, 12'd4095, 12'd4095}, '0, '0, 1'b0, none});
        dir_rows.push_back('{ROW_BOX, '{12'd4095, 12'd0, 12'd4095, 12'd1}, '0, '0, 1'b0, none});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_settings(row.thr, row.rule);
            else
                offer_box(row.box, row.typed, row.want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            write_settings(PHASE_THR[p][THR_W-1:0], PHASE_RULE[p]);
            send_idle_pct = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            for (int n = 0; n < BOXES_PER_PHASE; n++) begin
                // Long receiver hold-off while the sender keeps offering boxes.
                if (n == 20 && PHASE_SEND_IDLE[p] == 0 && PHASE_RECV_STALL[p] == 0)
                    stall_burst_req = 1'b1;
                offer_box(pick_box(), 1'b0, none);
            end
        end

        // Drain and allow for late stray results.
        face_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/core/fbs_pkg.sv
rtl/core/fbs_in_if.sv
rtl/core/fbs_out_if.sv
rtl/core/fbs_mul.sv
rtl/core/face_box_stabilizer_mouth_region.sv
verif/face_box_stabilizer_mouth_region_tb.sv
